// ===== src/tcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_pkg: shared types and constants of the text-mode character generator
// Opcodes, fixed field widths, request and result payloads, and the control
// group that the sequencer hands to the top level.
// ----------------------------------------------------------------------------
package tcg_pkg;

	// Default geometry
	localparam int COLUMNS_DEF      = 32;
	localparam int ROWS_DEF         = 32;
	localparam int GLYPH_HEIGHT_DEF = 8;

	// Fixed geometry of the font
	localparam int GLYPH_WIDTH = 8;
	localparam int GLYPH_COUNT = 64;
	localparam int CODE_W      = 6;

	// Field widths
	localparam int OP_W   = 2;
	localparam int ADDR_W = 10;
	localparam int DATA_W = 8;
	localparam int SCAN_W = 8;
	localparam int COL_W  = 5;

	// Opcodes
	localparam logic [OP_W-1:0] OP_SCREEN = 2'd0;
	localparam logic [OP_W-1:0] OP_FONT   = 2'd1;
	localparam logic [OP_W-1:0] OP_RENDER = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic [SCAN_W-1:0] scanline;
	} req_t;

	typedef struct packed {
		logic [GLYPH_WIDTH-1:0] pixel_bits;
		logic [COL_W-1:0]       column;
		logic                   last;
	} rsp_t;

	// Sequencer to datapath control
	typedef struct packed {
		logic clear;  // clearing pass: write zero at the screen address
		logic rd_en;  // walk: read the screen cell at the screen address
		logic last;   // the cell read now is the final column
	} seq_ctl_t;

endpackage

// ===== src/tcg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module tcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/tcg_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_seq: render sequencer of the character generator
// Runs the clearing pass after reset, splits a scanline into character row
// and glyph row, wraps the character row with one shared compare/subtract
// unit, and walks the columns of that row through one address adder.
// ----------------------------------------------------------------------------
module tcg_seq #(
	parameter int COLUMNS      = tcg_pkg::COLUMNS_DEF,
	parameter int ROWS         = tcg_pkg::ROWS_DEF,
	parameter int GLYPH_HEIGHT = tcg_pkg::GLYPH_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 render,
	input  logic [tcg_pkg::SCAN_W-1:0]           scanline,
	output logic                                 busy,
	output tcg_pkg::seq_ctl_t                    ctl,
	output logic [$clog2(COLUMNS*ROWS)-1:0]      scr_addr,
	output logic [$clog2(COLUMNS)-1:0]           col,
	output logic [$clog2(GLYPH_HEIGHT)-1:0]      glyph_row
);

	localparam int SCREEN_DEPTH = COLUMNS * ROWS;
	localparam int SA_W         = $clog2(SCREEN_DEPTH);
	localparam int COLI_W       = $clog2(COLUMNS);
	localparam int GR_W         = $clog2(GLYPH_HEIGHT);
	localparam int SCAN_W       = tcg_pkg::SCAN_W;
	// Quotient of scanline by glyph height
	localparam int QW           = $clog2(((1 << SCAN_W) - 1) / GLYPH_HEIGHT + 1);
	localparam int ROWS_W       = $clog2(ROWS + 1);
	localparam int RW           = (ROWS_W > QW) ? ROWS_W : QW;
	// Reciprocal of glyph height, exact for every 8-bit scanline
	localparam int RECIP_SH     = 16;
	localparam int RECIP        = ((1 << RECIP_SH) + GLYPH_HEIGHT - 1) / GLYPH_HEIGHT;
	localparam int PROD_W       = SCAN_W + RECIP_SH + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_WRAP,
		ST_BASE,
		ST_WALK
	} state_t;

	state_t              state_q;
	logic [SA_W-1:0]     clr_q;
	logic [COLI_W-1:0]   col_q;
	logic [SCAN_W-1:0]   scan_q;
	logic [QW-1:0]       quot_q;
	logic [RW-1:0]       row_q;
	logic [GR_W-1:0]     grow_q;
	logic [SA_W-1:0]     base_q;
	logic [PROD_W-1:0]   prod;
	logic                col_last;

	// Scanline times reciprocal, the quotient sits above the binary point
	assign prod     = PROD_W'(scan_q) * PROD_W'(RECIP);
	assign col_last = (col_q == COLI_W'(COLUMNS - 1));

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SA_W'(SCREEN_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (render) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					if (row_q < RW'(ROWS)) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					col_q   <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					col_q <= col_q + 1'b1;
					if (col_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Row and address arithmetic
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (render) begin
					scan_q <= scanline;
				end
			end
			ST_DIV: begin
				quot_q <= prod[RECIP_SH +: QW];
			end
			ST_REM: begin
				grow_q <= GR_W'(scan_q - SCAN_W'(SCAN_W'(quot_q) * SCAN_W'(GLYPH_HEIGHT)));
				row_q  <= RW'(quot_q);
			end
			ST_WRAP: begin
				// Shared compare/subtract: wrap the character row
				if (row_q >= RW'(ROWS)) begin
					row_q <= row_q - RW'(ROWS);
				end
			end
			ST_BASE: begin
				base_q <= SA_W'(SA_W'(row_q) * SA_W'(COLUMNS));
			end
			default: begin
			end
		endcase
	end

	// Control outputs
	assign busy      = (state_q != ST_IDLE);
	assign ctl.clear = (state_q == ST_CLEAR);
	assign ctl.rd_en = (state_q == ST_WALK);
	assign ctl.last  = (state_q == ST_WALK) && col_last;
	assign scr_addr  = (state_q == ST_CLEAR) ? clr_q : (base_q + SA_W'(col_q));
	assign col       = col_q;
	assign glyph_row = grow_q;

endmodule

// ===== src/text_mode_character_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_character_generator: text-mode video character generator
// Holds a screen store of character bytes and an 8-pixel-wide font store,
// takes screen and font writes, and renders one pixel scanline as one
// eight-pixel result per character column, left to right.
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  request   start, busy, req      taken at a clock edge with start high, busy low
//  result    strobe, rsp           one cycle per result, cannot be held off
//
//  Screen and font writes complete at the edge that takes them and leave busy low.
//  A render holds busy through the divide, remainder, row wrap (repeated until
//  the row is below ROWS), base and walk states; one result per cycle follows the
//  column walk, behind the registered screen read and the registered font read.
//  After reset a clearing pass zeroes all COLUMNS * ROWS cells (1024 by default)
//  of the screen store, one cell a cycle, with busy high.
//  Results leave at a fixed rate; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module text_mode_character_generator #(
	parameter int COLUMNS      = tcg_pkg::COLUMNS_DEF,
	parameter int ROWS         = tcg_pkg::ROWS_DEF,
	parameter int GLYPH_HEIGHT = tcg_pkg::GLYPH_HEIGHT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tcg_pkg::req_t req,
	output logic          strobe,
	output tcg_pkg::rsp_t rsp
);

	localparam int SCREEN_DEPTH = COLUMNS * ROWS;
	localparam int FONT_DEPTH   = tcg_pkg::GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int SA_W         = $clog2(SCREEN_DEPTH);
	localparam int FA_W         = $clog2(FONT_DEPTH);
	localparam int COLI_W       = $clog2(COLUMNS);
	localparam int GR_W         = $clog2(GLYPH_HEIGHT);
	localparam int DATA_W       = tcg_pkg::DATA_W;

	tcg_pkg::seq_ctl_t   ctl;
	logic                accept;
	logic                render;
	logic [SA_W-1:0]     scr_addr;
	logic [COLI_W-1:0]   col;
	logic [GR_W-1:0]     glyph_row;

	logic                scr_we;
	logic [SA_W-1:0]     scr_waddr;
	logic [DATA_W-1:0]   scr_wdata;
	logic [DATA_W-1:0]   scr_rdata;

	logic                font_we;
	logic [FA_W-1:0]     font_raddr;
	logic [DATA_W-1:0]   font_rdata;

	logic                valid_s1;
	logic                last_s1;
	logic [COLI_W-1:0]   col_s1;
	logic                valid_s2;
	logic                last_s2;
	logic [COLI_W-1:0]   col_s2;

	// Decode the request
	assign accept = start && !busy;
	assign render = accept && (req.opcode == tcg_pkg::OP_RENDER);

	tcg_seq #(
		.COLUMNS      (COLUMNS),
		.ROWS         (ROWS),
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.render    (render),
		.scanline  (req.scanline),
		.busy      (busy),
		.ctl       (ctl),
		.scr_addr  (scr_addr),
		.col       (col),
		.glyph_row (glyph_row)
	);

	// Screen store: clearing pass or in-range screen write
	assign scr_we    = ctl.clear ||
		(accept && (req.opcode == tcg_pkg::OP_SCREEN) && (32'(req.address) < SCREEN_DEPTH));
	assign scr_waddr = ctl.clear ? scr_addr : SA_W'(req.address);
	assign scr_wdata = ctl.clear ? '0 : req.data;

	tcg_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SCREEN_DEPTH)
	) u_screen_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.re    (ctl.rd_en),
		.raddr (scr_addr),
		.rdata (scr_rdata)
	);

	// Font store: glyph row address from the masked character code
	assign font_we    = accept && (req.opcode == tcg_pkg::OP_FONT) &&
		(32'(req.address) < FONT_DEPTH);
	assign font_raddr = FA_W'(FA_W'(scr_rdata[tcg_pkg::CODE_W-1:0]) * FA_W'(GLYPH_HEIGHT))
		+ FA_W'(glyph_row);

	tcg_ram #(
		.WIDTH (DATA_W),
		.DEPTH (FONT_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (font_we),
		.waddr (FA_W'(req.address)),
		.wdata (req.data),
		.re    (valid_s1),
		.raddr (font_raddr),
		.rdata (font_rdata)
	);

	// Advance the column tag alongside the two reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= ctl.last;
		col_s1  <= col;
		last_s2 <= last_s1;
		col_s2  <= col_s1;
	end

	// Drive the result
	assign strobe         = valid_s2;
	assign rsp.pixel_bits = font_rdata;
	assign rsp.column     = tcg_pkg::COL_W'(col_s2);
	assign rsp.last       = last_s2;

`ifndef SYNTH
	// A cell read always yields a result, behind the registered screen and font reads
	a_read_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |=> ##1 strobe)
		else $error("screen read produced no result");

	// Results of one scanline come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !rsp.last |=> strobe)
		else $error("gap inside a scanline");

	// The final result carries the final column
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.last |-> (col_s2 == COLI_W'(COLUMNS - 1)))
		else $error("last flag on wrong column");

	// An accepted render raises busy
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		render |=> busy)
		else $error("render accepted without going busy");
`endif

endmodule
